// ----- src/grr_pkg.sv -----
// Shared constants and types for the group reverse reorder block.
package grr_pkg;

  localparam int unsigned MAX_GROUP_DEF = 64;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned GSIZE_W       = 7;

  typedef enum logic [0:0] {
    GRR_IDLE,
    GRR_DRAIN
  } grr_state_e;

  // Read request from the sequencer to the output pipeline
  typedef struct packed {
    logic re;
    logic last;
  } grr_rd_t;

endpackage

// ----- src/group_reverse_reorder_core.sv -----
// Top level: stream reorder that reverses values in groups of a configurable size.
//
// Values enter one per beat on the slave stream and are written into a group RAM of
// MAX_GROUP entries. When the held count reaches the configured group size, the whole
// group leaves on the master stream newest first; when a beat with tlast arrives on a
// partial group, that tail leaves in arrival order. Either way the final beat of the
// run carries tlast. While a run drains, the block does not take input and reads the
// RAM once per cycle, except while master backpressure holds the read stage. A group
// size of zero acts as one, and sizes above MAX_GROUP act as MAX_GROUP. Write the group
// size only while the block is idle.
module group_reverse_reorder_core #(
  parameter int unsigned MAX_GROUP = grr_pkg::MAX_GROUP_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: group size
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [grr_pkg::GSIZE_W-1:0]         cfg_data_i,
  // Slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic signed [grr_pkg::VALUE_W-1:0]  s_axis_tdata,  // [31:0] value
  input  logic                                s_axis_tlast,  // end_of_list
  // Master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic signed [grr_pkg::VALUE_W-1:0]  m_axis_tdata,  // [31:0] out_value
  output logic                                m_axis_tlast   // run_last
);

  localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned CW = $clog2(MAX_GROUP + 1);

  logic [grr_pkg::GSIZE_W-1:0] gsize_q;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;
  grr_pkg::grr_rd_t            rd;
  logic [grr_pkg::VALUE_W-1:0] rdata;

  logic rv_q, rv_d;
  logic rlast_q, rlast_d;
  logic mvalid_q, mvalid_d;
  logic mlast_q;
  logic [grr_pkg::VALUE_W-1:0] mdata_q;
  logic out_free;
  logic advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsize_q <= grr_pkg::GSIZE_W'(1);
    end else if (cfg_valid_i) begin
      gsize_q <= cfg_data_i;
    end
  end

  grr_seq #(
    .MAX_GROUP (MAX_GROUP),
    .AW        (AW),
    .CW        (CW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .gsize_i    (gsize_q),
    .advance_i  (advance),
    .in_ready_o (s_axis_tready),
    .we_o       (we),
    .waddr_o    (waddr),
    .rd_o       (rd),
    .raddr_o    (raddr)
  );

  grr_ram #(
    .WIDTH (grr_pkg::VALUE_W),
    .DEPTH (MAX_GROUP),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata),
    .re_i    (rd.re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // RAM read stage feeds the output register; hold the read data while output stalls
  assign out_free = !mvalid_q || m_axis_tready;
  assign advance  = !rv_q || out_free;

  always_comb begin
    rv_d     = rv_q;
    rlast_d  = rlast_q;
    mvalid_d = mvalid_q;
    if (advance) begin
      rv_d    = rd.re;
      rlast_d = rd.last;
    end
    if (out_free) begin
      mvalid_d = rv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q     <= 1'b0;
      rlast_q  <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      rv_q     <= rv_d;
      rlast_q  <= rlast_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && rv_q) begin
      mdata_q <= rdata;
      mlast_q <= rlast_q;
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tlast  = mlast_q;

endmodule

// ----- src/grr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module grr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/grr_seq.sv -----
// Fill counter and drain sequencer: decides when a group is emitted and walks its addresses.
module grr_seq #(
  parameter int unsigned MAX_GROUP = grr_pkg::MAX_GROUP_DEF,
  parameter int unsigned AW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
  parameter int unsigned CW        = $clog2(MAX_GROUP + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_last_i,
  input  logic [grr_pkg::GSIZE_W-1:0]  gsize_i,
  input  logic                         advance_i,
  output logic                         in_ready_o,
  output logic                         we_o,
  output logic [AW-1:0]                waddr_o,
  output grr_pkg::grr_rd_t             rd_o,
  output logic [AW-1:0]                raddr_o
);

  localparam int unsigned KW = (CW > grr_pkg::GSIZE_W) ? CW : grr_pkg::GSIZE_W;
  localparam logic [KW-1:0] MAX_K = KW'(MAX_GROUP);

  grr_pkg::grr_state_e state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [CW-1:0] left_q, left_d;
  logic          rev_q, rev_d;

  logic          accept;
  logic [KW-1:0] n_ext;
  logic [KW-1:0] gs_ext;
  logic          full;

  assign in_ready_o = (state_q == grr_pkg::GRR_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign n_ext      = KW'(fill_q) + KW'(1);
  assign gs_ext     = KW'(gsize_i);
  // Size zero counts as one: n is at least one, so n >= 0 already emits
  assign full       = (n_ext >= gs_ext) || (n_ext >= MAX_K);

  assign we_o    = accept;
  assign waddr_o = fill_q[AW-1:0];
  assign raddr_o = addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grr_pkg::GRR_IDLE;
      fill_q  <= '0;
      addr_q  <= '0;
      left_q  <= '0;
      rev_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      addr_q  <= addr_d;
      left_q  <= left_d;
      rev_q   <= rev_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    addr_d     = addr_q;
    left_d     = left_q;
    rev_d      = rev_q;
    rd_o.re    = 1'b0;
    rd_o.last  = 1'b0;
    unique case (state_q)
      grr_pkg::GRR_IDLE: begin
        if (accept) begin
          if (full || in_last_i) begin
            // Full group walks down from the newest entry, a tail walks up from zero
            fill_d  = '0;
            rev_d   = full;
            addr_d  = full ? fill_q[AW-1:0] : '0;
            left_d  = n_ext[CW-1:0];
            state_d = grr_pkg::GRR_DRAIN;
          end else begin
            fill_d = fill_q + CW'(1);
          end
        end
      end
      grr_pkg::GRR_DRAIN: begin
        if (advance_i) begin
          rd_o.re   = 1'b1;
          rd_o.last = (left_q == CW'(1));
          left_d    = left_q - CW'(1);
          addr_d    = rev_q ? (addr_q - AW'(1)) : (addr_q + AW'(1));
          if (left_q == CW'(1)) begin
            state_d = grr_pkg::GRR_IDLE;
          end
        end
      end
      default: state_d = grr_pkg::GRR_IDLE;
    endcase
  end

endmodule

// ----- test/group_reverse_reorder_core_tb.sv -----
// Self-checking testbench for group_reverse_reorder_core: group reversal, tails and size changes.
module group_reverse_reorder_core_tb;

  localparam int unsigned MAX_GROUP = grr_pkg::MAX_GROUP_DEF;
  localparam int unsigned VALUE_W   = grr_pkg::VALUE_W;
  localparam int unsigned GSIZE_W   = grr_pkg::GSIZE_W;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } out_beat_t;

  // Predicts the reordered stream and checks each output beat against it.
  class reversal_scoreboard;
    logic [GSIZE_W-1:0]        group_size;
    logic signed [VALUE_W-1:0] held_values [MAX_GROUP];
    int unsigned               held_count;
    out_beat_t                 due_beats [$];
    int unsigned               mismatches;
    int unsigned               beats_checked;
    int unsigned               runs_predicted;

    function new();
      group_size     = GSIZE_W'(1);
      held_count     = 0;
      mismatches     = 0;
      beats_checked  = 0;
      runs_predicted = 0;
    endfunction

    function void set_size(logic [GSIZE_W-1:0] s);
      group_size = s;
    endfunction

    function int unsigned pending();
      return due_beats.size();
    endfunction

    function void push_beat(logic signed [VALUE_W-1:0] v, logic last);
      out_beat_t b;
      b.value = v;
      b.last  = last;
      due_beats.push_back(b);
    endfunction

    function void note_value(logic signed [VALUE_W-1:0] v, logic eol);
      int unsigned k;
      int n;
      // Zero acts as one, oversize saturates
      if (group_size == 0) k = 1;
      else if (group_size > MAX_GROUP) k = MAX_GROUP;
      else k = group_size;
      if (held_count < MAX_GROUP) begin
        held_values[held_count] = v;
        held_count++;
      end
      n = held_count;
      if (n >= k) begin
        for (int i = n - 1; i >= 0; i--) push_beat(held_values[i], i == 0);
        held_count = 0;
        runs_predicted++;
      end else if (eol) begin
        for (int i = 0; i < n; i++) push_beat(held_values[i], i == n - 1);
        held_count = 0;
        runs_predicted++;
      end
    endfunction

    function void check_beat(logic signed [VALUE_W-1:0] v, logic last);
      out_beat_t exp_b;
      beats_checked++;
      if (due_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: value %0d last %0b", v, last);
        return;
      end
      exp_b = due_beats.pop_front();
      if (exp_b.value !== v || exp_b.last !== last) begin
        mismatches++;
        if (mismatches <= 10) begin
          if (exp_b.value !== v)
            $display("beat %0d value: expected %0d, got %0d", beats_checked, exp_b.value, v);
          if (exp_b.last !== last)
            $display("beat %0d last: expected %0b, got %0b", beats_checked, exp_b.last, last);
        end
      end
    endfunction
  endclass

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [GSIZE_W-1:0]        cfg_data_i    = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic signed [VALUE_W-1:0] s_axis_tdata  = '0;
  logic                      s_axis_tlast  = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic signed [VALUE_W-1:0] m_axis_tdata;
  logic                      m_axis_tlast;

  bit                 steady = 1'b0;
  int unsigned        values_sent = 0;
  int unsigned        sizes_written = 0;
  reversal_scoreboard sb = new();

  group_reverse_reorder_core #(.MAX_GROUP(MAX_GROUP)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 38);
  end

  // Note the input beat before checking output so a same-edge passthrough is covered
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_value(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tlast);
    end
  end

  task automatic send_value(logic signed [VALUE_W-1:0] v, logic eol);
    while (!steady && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= eol;
    do @(posedge clk_i); while (!s_axis_tready);
    values_sent++;
  endtask

  // Hold input until all predicted beats are out, then let the block settle back to idle
  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_group_size(logic [GSIZE_W-1:0] s);
    drain_wait();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= s;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_size(s);
    sizes_written++;
  endtask

  initial begin
    int phase_sizes [14] = '{127, 4, 2, 9, 1, 33, 64, 3, 0, 6, 5, 8, 17, 2};
    int unsigned count;
    int guard;
    logic eol;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset size of one: extremes pass straight through
    send_value(32'sh7FFF_FFFF, 1'b0);
    send_value(32'sh8000_0000, 1'b1);

    // Size zero acts as one
    write_group_size(7'd0);
    send_value(32'shFFFF_FFFF, 1'b0);
    send_value(32'sh0000_0000, 1'b1);

    // Full group, partial tail, then a group completed by the end-of-list beat
    write_group_size(7'd3);
    send_value(32'sd11, 1'b0);
    send_value(32'sd12, 1'b0);
    send_value(32'sd13, 1'b0);
    send_value(-32'sd21, 1'b0);
    send_value(-32'sd22, 1'b1);
    send_value(32'sd31, 1'b0);
    send_value(32'sd32, 1'b0);
    send_value(32'sd33, 1'b1);

    // Shrink the size under a held partial group
    write_group_size(7'd5);
    send_value(32'sd41, 1'b0);
    send_value(32'sd42, 1'b0);
    send_value(32'sd43, 1'b0);
    send_value(32'sd44, 1'b0);
    write_group_size(7'd2);
    send_value(32'sd45, 1'b0);

    // Grow the size under a held partial group, then end the list early
    write_group_size(7'd4);
    send_value(32'sd51, 1'b0);
    write_group_size(7'd6);
    send_value(32'sd52, 1'b0);
    send_value(32'sd53, 1'b1);

    // Random phases, oversize and the largest size included
    foreach (phase_sizes[p]) begin
      write_group_size(phase_sizes[p][GSIZE_W-1:0]);
      steady = (p == 3 || p == 4);
      count = (phase_sizes[p] >= 32) ? 70 : 16;
      for (int i = 0; i < count; i++) begin
        if (i == count - 1) eol = 1'($urandom_range(1));
        else eol = ($urandom_range(phase_sizes[p] >= 32 ? 39 : 11) == 0);
        send_value($urandom(), eol);
        // Stall the sender once until the output has fully caught up
        if (p == 1 && i == 10) drain_wait();
      end
    end
    steady = 1'b0;

    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (80) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0d predicted beats never arrived", sb.pending());
      sb.mismatches += sb.pending();
    end

    $display("Sent %0d values over %0d group size writes; checked %0d output beats in %0d runs.",
             values_sent, sizes_written, sb.beats_checked, sb.runs_predicted);
    $display("Mismatching beats: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Run timed out");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
src/grr_pkg.sv
src/grr_ram.sv
src/grr_seq.sv
src/group_reverse_reorder_core.sv
test/group_reverse_reorder_core_tb.sv
